>>> design/sha1mh_pkg.sv
`timescale 1ns / 1ps

package sha1mh_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // sequencer to round unit
  typedef struct packed {
    logic        push;
    logic [31:0] word;
    logic        start;
    logic        restart;
  } core_ctl_t;

  // round unit to sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

  typedef logic [4:0][31:0] chain_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [2:0] LAST_IDX = 3'd4;

endpackage

>>> design/sha1mh_round_unit.sv
`timescale 1ns / 1ps

module sha1mh_round_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sha1mh_pkg::core_ctl_t ctl_i,
  output sha1mh_pkg::core_sts_t sts_o,
  output sha1mh_pkg::chain_t    chain_o
);

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hefcdab89;
  localparam logic [31:0] H2 = 32'h98badcfe;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hc3d2e1f0;
  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;
  localparam logic [6:0]  LAST_ROUND = 7'd79;

  logic [31:0] w_q [16];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  sha1mh_pkg::chain_t h_q;
  logic [6:0] round_q;
  logic       busy_q, ff_q, done_q;

  logic [31:0] f, k, t, w_new, w_mix;
  logic        rounding;

  assign rounding = busy_q && !ff_q;

  always_comb begin
    if (round_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = K0;
    end else if (round_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
      k = K1;
    end else if (round_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = K2;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = K3;
    end
    t     = {a_q[26:0], a_q[31:27]} + f + e_q + w_q[0] + k;
    w_mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    w_new = {w_mix[30:0], w_mix[31]};
  end

  // schedule window: fill from the packer, expand during rounds
  always_ff @(posedge clk_i) begin
    if (ctl_i.push || rounding) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= rounding ? w_new : ctl_i.word;
    end
    if (ctl_i.start) begin
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
      e_q <= h_q[4];
    end else if (rounding) begin
      a_q <= t;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q     <= {H4, H3, H2, H1, H0};
      round_q <= '0;
      busy_q  <= 1'b0;
      ff_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.restart) begin
        h_q <= {H4, H3, H2, H1, H0};
      end
      if (ctl_i.start) begin
        busy_q  <= 1'b1;
        round_q <= '0;
      end else if (rounding) begin
        round_q <= round_q + 7'd1;
        if (round_q == LAST_ROUND) begin
          ff_q <= 1'b1;
        end
      end else if (ff_q) begin
        // feed-forward into the chaining words
        h_q[0] <= h_q[0] + a_q;
        h_q[1] <= h_q[1] + b_q;
        h_q[2] <= h_q[2] + c_q;
        h_q[3] <= h_q[3] + d_q;
        h_q[4] <= h_q[4] + e_q;
        ff_q   <= 1'b0;
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign chain_o    = h_q;

endmodule

>>> design/sha1_message_hasher.sv
`timescale 1ns / 1ps
// byte input: the 64th byte of a block starts a compression (80 rounds plus feed-forward)
// in the shared round unit, and no further byte is accepted until it is done
// closing: padding is pushed one byte a cycle with one or two block compressions,
// then five digest words, one per accepted cycle
// the one-round-per-cycle unit bounds the block rate, as byte intake stalls while it works
// reset: asynchronous active low; chaining words take the SHA-1 initial values, counts clear

module sha1_message_hasher (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sha1mh_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sha1mh_pkg::out_item_t out_data_o
);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // accepting message bytes
  localparam logic [1:0] ST_COMP = 2'd1;  // round unit working on a block
  localparam logic [1:0] ST_PAD  = 2'd2;  // pushing padding and length bytes
  localparam logic [1:0] ST_OUT  = 2'd3;  // handing out the digest words

  logic [1:0]  state_q, state_d;
  logic [5:0]  fill_q, fill_d;        // bytes in the current block
  logic [23:0] acc_q, acc_d;          // partial big-endian word
  logic [63:0] bit_len_q, bit_len_d;  // message length in bits, wraps
  logic        pad_q, pad_d;          // message is being closed
  logic        first_q, first_d;      // the 0x80 marker is still to go
  logic        len_ok_q, len_ok_d;    // this block may take the length field
  logic        final_q, final_d;      // the running compression is the last one
  logic [2:0]  widx_q, widx_d;        // digest word being offered

  logic        push_en;
  logic [7:0]  push_byte;
  logic [63:0] len_shift;
  logic [7:0]  len_byte;
  logic        restart;

  sha1mh_pkg::core_ctl_t core_ctl;
  sha1mh_pkg::core_sts_t core_sts;
  sha1mh_pkg::chain_t    chain;

  // length bytes go out most significant first at block positions 56..63
  assign len_shift = bit_len_q >> {3'd7 - fill_q[2:0], 3'b000};
  assign len_byte  = len_shift[7:0];

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    acc_d     = acc_q;
    bit_len_d = bit_len_q;
    pad_d     = pad_q;
    first_d   = first_q;
    len_ok_d  = len_ok_q;
    final_d   = final_q;
    widx_d    = widx_q;
    push_en   = 1'b0;
    push_byte = in_data_i.data_byte;
    restart   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.byte_valid) begin
            push_en   = 1'b1;
            bit_len_d = bit_len_q + 64'd8;
          end
          if (in_data_i.end_of_message) begin
            pad_d   = 1'b1;
            first_d = 1'b1;
          end
          if (in_data_i.byte_valid && fill_q == sha1mh_pkg::LAST_POS) begin
            state_d = ST_COMP;
          end else if (in_data_i.end_of_message) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_COMP: begin
        if (core_sts.done) begin
          if (final_q) begin
            final_d = 1'b0;
            state_d = ST_OUT;
          end else if (pad_q) begin
            // a fresh block after a spill always has room for the length
            len_ok_d = 1'b1;
            state_d  = ST_PAD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_PAD: begin
        push_en = 1'b1;
        if (first_q) begin
          push_byte = sha1mh_pkg::PAD_BYTE;
          first_d   = 1'b0;
          len_ok_d  = (fill_q < sha1mh_pkg::LEN_POS);
        end else if (len_ok_q && fill_q >= sha1mh_pkg::LEN_POS) begin
          push_byte = len_byte;
          if (fill_q == sha1mh_pkg::LAST_POS) begin
            final_d = 1'b1;
          end
        end else begin
          push_byte = 8'h00;
        end
        if (fill_q == sha1mh_pkg::LAST_POS) begin
          state_d = ST_COMP;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          if (widx_q == sha1mh_pkg::LAST_IDX) begin
            widx_d    = '0;
            pad_d     = 1'b0;
            bit_len_d = '0;
            restart   = 1'b1;
            state_d   = ST_IDLE;
          end else begin
            widx_d = widx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (push_en) begin
      fill_d = fill_q + 6'd1;
      acc_d  = {acc_q[15:0], push_byte};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      bit_len_q <= '0;
      pad_q     <= 1'b0;
      first_q   <= 1'b0;
      len_ok_q  <= 1'b0;
      final_q   <= 1'b0;
      widx_q    <= '0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      bit_len_q <= bit_len_d;
      pad_q     <= pad_d;
      first_q   <= first_d;
      len_ok_q  <= len_ok_d;
      final_q   <= final_d;
      widx_q    <= widx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // every fourth byte completes a word for the schedule window
  assign core_ctl.push    = push_en && (fill_q[1:0] == 2'b11);
  assign core_ctl.word    = {acc_q, push_byte};
  assign core_ctl.start   = push_en && (fill_q == sha1mh_pkg::LAST_POS);
  assign core_ctl.restart = restart;

  sha1mh_round_unit u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (core_ctl),
    .sts_o   (core_sts),
    .chain_o (chain)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  always_comb begin
    case (widx_q)
      3'd0:    out_data_o.digest_word = chain[0];
      3'd1:    out_data_o.digest_word = chain[1];
      3'd2:    out_data_o.digest_word = chain[2];
      3'd3:    out_data_o.digest_word = chain[3];
      default: out_data_o.digest_word = chain[4];
    endcase
  end
  assign out_data_o.word_index = widx_q;
  assign out_data_o.last_word  = (widx_q == sha1mh_pkg::LAST_IDX);

`ifndef SYNTHESIS
  // bytes are only taken while the round unit is free
  a_idle_core: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !core_sts.busy)
    else $error("transaction accepted while round unit busy");

  // a compression only starts on a full block
  a_start_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_ctl.start |-> (core_ctl.push && fill_q == sha1mh_pkg::LAST_POS))
    else $error("compression started on a partial block");

  // digest word index stays in range
  a_widx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (widx_q <= sha1mh_pkg::LAST_IDX))
    else $error("digest word index out of range");

  // after the last digest word the message state is cleared
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.last_word) |=>
      (state_q == ST_IDLE && bit_len_q == 64'd0 && fill_q == 6'd0))
    else $error("message state not cleared after digest");

  // digest is only offered when the block boundary is clean
  a_out_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fill_q == 6'd0 && !core_sts.busy))
    else $error("digest offered with work pending");
`endif

endmodule
